// File: hdl/smv_pkg.sv
`default_nettype none
package smv_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_W      = 5;
  localparam int LEN_RESET  = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_W-1:0]           cfg_t;

  // per-cell flags shared along the chain
  typedef struct packed {
    logic le;         // cell value <= incoming sample
    logic del_hit;    // cell holds the oldest sample
    logic del_below;  // oldest sample sits in a lower cell
  } smv_flags_t;

endpackage
`default_nettype wire

// File: hdl/smv_in_if.sv
`default_nettype none
interface smv_in_if
  import smv_pkg::*;
  ;
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// File: hdl/smv_out_if.sv
`default_nettype none
interface smv_out_if
  import smv_pkg::*;
  ;
  logic    valid;
  logic    ready;
  sample_t median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface
`default_nettype wire

// File: hdl/sliding_window_median.sv
`default_nettype none
// Running median over the last window_length samples (1..WINDOW_MAX).
// On accept the sorted chain of WINDOW_MAX cells takes the insertion and
// eviction; the median is then registered into the output when free.
// Throughput: one sample per cycle while the output does not stall.
// Reset: history all zero, window_length 5, no beat pending.
module sliding_window_median
  import smv_pkg::*;
#(
  parameter int WINDOW_MAX = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire cfg_t       cfg_wdata,
  smv_in_if.sink          in_chan,
  smv_out_if.source       out_chan
);

  localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  cfg_t             cfg_r;
  logic             pend_r;
  logic             out_valid_r;
  sample_t          out_median_r;
  logic             shift, load;
  logic [LEN_W-1:0] len;
  sample_t          median;

  sample_t          vals  [WINDOW_MAX];
  logic [AGE_W-1:0] ages  [WINDOW_MAX];
  smv_flags_t       flags [WINDOW_MAX];

  assign load           = pend_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !pend_r || load;
  assign shift          = in_chan.valid && in_chan.ready;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.median = out_median_r;

  always_comb begin
    if (cfg_r == '0) begin
      len = LEN_W'(1);
    end else if (CMP_W'(cfg_r) > CMP_W'(WINDOW_MAX)) begin
      len = LEN_W'(WINDOW_MAX);
    end else begin
      len = LEN_W'(cfg_r);
    end
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    sample_t          p_val, n_val;
    logic [AGE_W-1:0] p_age, n_age;
    smv_flags_t       p_flg, n_flg;

    if (i == 0) begin : g_head
      assign p_val = '0;
      assign p_age = '0;
      assign p_flg = '{le: 1'b1, del_hit: 1'b0, del_below: 1'b0};
    end else begin : g_link_lo
      assign p_val = vals[i-1];
      assign p_age = ages[i-1];
      assign p_flg = flags[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_tail
      assign n_val = '0;
      assign n_age = '0;
      assign n_flg = '{le: 1'b0, del_hit: 1'b0, del_below: 1'b0};
    end else begin : g_link_hi
      assign n_val = vals[i+1];
      assign n_age = ages[i+1];
      assign n_flg = flags[i+1];
    end

    smv_cell #(
      .AGE_W (AGE_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift      (shift),
      .new_sample (in_chan.sample),
      .oldest_age (AGE_W'(WINDOW_MAX - 1)),
      .init_age   (AGE_W'(i)),
      .prev_val   (p_val),
      .prev_age   (p_age),
      .prev_flags (p_flg),
      .next_val   (n_val),
      .next_age   (n_age),
      .next_flags (n_flg),
      .val        (vals[i]),
      .age        (ages[i]),
      .flags      (flags[i])
    );
  end

  smv_select #(
    .DEPTH (WINDOW_MAX),
    .AGE_W (AGE_W),
    .LEN_W (LEN_W)
  ) u_select (
    .vals   (vals),
    .ages   (ages),
    .len    (len),
    .median (median)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= cfg_t'(LEN_RESET);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (shift) begin
        pend_r <= 1'b1;
      end else if (load) begin
        pend_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_median_r <= median;
    end
  end

endmodule
`default_nettype wire

// File: hdl/smv_cell.sv
`default_nettype none
module smv_cell
  import smv_pkg::*;
#(
  parameter int AGE_W = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             shift,
  input  wire sample_t          new_sample,
  input  wire logic [AGE_W-1:0] oldest_age,
  input  wire logic [AGE_W-1:0] init_age,
  input  wire sample_t          prev_val,
  input  wire logic [AGE_W-1:0] prev_age,
  input  wire smv_flags_t       prev_flags,
  input  wire sample_t          next_val,
  input  wire logic [AGE_W-1:0] next_age,
  input  wire smv_flags_t       next_flags,
  output      sample_t          val,
  output      logic [AGE_W-1:0] age,
  output      smv_flags_t       flags
);

  sample_t          val_r, val_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic             take_next, take_self_lo;
  logic             ci_le, cim1_le;
  sample_t          ci_val, cim1_val;
  logic [AGE_W-1:0] ci_age, cim1_age;

  assign val = val_r;
  assign age = age_r;

  always_comb begin
    flags.le        = (val_r <= new_sample);
    flags.del_hit   = (age_r == oldest_age);
    flags.del_below = prev_flags.del_below | prev_flags.del_hit;
  end

  // compacted list (oldest removed): entry here and entry one below
  always_comb begin
    take_next    = flags.del_below | flags.del_hit;
    take_self_lo = flags.del_below;
    ci_le    = take_next ? next_flags.le : flags.le;
    ci_val   = take_next ? next_val : val_r;
    ci_age   = take_next ? next_age : age_r;
    cim1_le  = take_self_lo ? flags.le : prev_flags.le;
    cim1_val = take_self_lo ? val_r : prev_val;
    cim1_age = take_self_lo ? age_r : prev_age;

    if (ci_le) begin
      val_nxt = ci_val;
      age_nxt = ci_age + AGE_W'(1);
    end else if (cim1_le) begin
      val_nxt = new_sample;
      age_nxt = '0;
    end else begin
      val_nxt = cim1_val;
      age_nxt = cim1_age + AGE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      age_r <= init_age;
    end else if (shift) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/smv_select.sv
`default_nettype none
module smv_select
  import smv_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AGE_W = 4,
  parameter int LEN_W = 5
) (
  input  wire sample_t          vals [DEPTH],
  input  wire logic [AGE_W-1:0] ages [DEPTH],
  input  wire logic [LEN_W-1:0] len,
  output      sample_t          median
);

  localparam int CMP_W = (LEN_W > AGE_W) ? LEN_W : AGE_W;

  logic [DEPTH-1:0] in_win;
  logic [DEPTH-1:0] hit;
  logic [LEN_W-1:0] target;
  logic [LEN_W-1:0] rank [DEPTH];

  assign target = len >> 1;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      in_win[i] = (CMP_W'(ages[i]) < CMP_W'(len));
    end
    for (int i = 0; i < DEPTH; i++) begin
      rank[i] = LEN_W'($countones(in_win & ((DEPTH'(1) << i) - DEPTH'(1))));
      hit[i]  = in_win[i] && (rank[i] == target);
    end
    median = '0;
    for (int i = 0; i < DEPTH; i++) begin
      median = median | (hit[i] ? vals[i] : sample_t'(0));
    end
  end

endmodule
`default_nettype wire
